// File: rtl/echo_hiding_embedder_macros.svh
// Assertion macros shared by the echo hiding embedder RTL.
// Include by bare file name; no other dependencies.
`ifndef ECHO_HIDING_EMBEDDER_MACROS_SVH
`define ECHO_HIDING_EMBEDDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EHE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ehe_pkg.sv
// Package for the echo hiding embedder: sizes, ramp constants, codes and helpers.
// No dependencies; imported by the top level.
`default_nettype none

package ehe_pkg;

    localparam int FRAME_LEN  = 4096;
    localparam int DELAY_MAX  = 1024;

    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int ADDR_W     = $clog2(DELAY_MAX);
    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 11;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int RAMP_START = FRAME_LEN * 95 / 100;
    localparam int RAMP_LEN   = 2 * (FRAME_LEN - RAMP_START);
    localparam int RAMP_HALF  = RAMP_LEN / 2;
    localparam int HEAD_END   = FRAME_LEN - RAMP_START;

    localparam int WEIGHT_W   = 17;
    localparam int WEIGHT_ONE = 65536;
    localparam int FRAC_STEP  = WEIGHT_ONE / RAMP_LEN;
    localparam int REM_STEP   = WEIGHT_ONE % RAMP_LEN;
    localparam int HEAD_FRAC0 = (HEAD_END * WEIGHT_ONE + RAMP_HALF) / RAMP_LEN;
    localparam int HEAD_REM0  = (HEAD_END * WEIGHT_ONE + RAMP_HALF) % RAMP_LEN;
    localparam int TAIL_FRAC0 = RAMP_HALF / RAMP_LEN;
    localparam int TAIL_REM0  = RAMP_HALF % RAMP_LEN;
    localparam int REM_W      = $clog2(2 * RAMP_LEN);

    localparam int MUL_W      = 18;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int BLEND_W    = 34;
    localparam int ACC_W      = 50;
    localparam int ROUND_POS  = 31;
    localparam int ECHO_W     = ACC_W - ROUND_POS;
    localparam int SUM_W      = 20;
    localparam longint ROUND_BIAS = 64'd1 << (ROUND_POS - 1);
    localparam int SAT_MAX    = 32767;
    localparam int SAT_MIN    = -32768;

    localparam int RST_DELAY_ZERO   = 250;
    localparam int RST_DELAY_ONE    = 300;
    localparam int RST_ECHO_GAIN    = 13107;
    localparam int RST_SMOOTHING_ON = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_ZERO,
        REG_DELAY_ONE,
        REG_ECHO_GAIN,
        REG_SMOOTHING_ON
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_MUL1,
        S_BLEND,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_OUT
    } t_state;

    // A delay of zero acts as one and delays beyond the line saturate.
    function automatic logic [ADDR_W-1:0] lag_of(input logic [DELAY_W-1:0] d);
        logic [ADDR_W-1:0] lag;
        if (d == '0) begin
            lag = '0;
        end else if (32'(d) > 32'(DELAY_MAX)) begin
            lag = ADDR_W'(DELAY_MAX - 1);
        end else begin
            lag = ADDR_W'(d - DELAY_W'(1));
        end
        return lag;
    endfunction

    function automatic logic [WEIGHT_W-1:0] ramp_weight(input logic a, input logic b,
                                                      input logic [WEIGHT_W-1:0] frac);
        logic [WEIGHT_W-1:0] w;
        if (a == b) begin
            w = a ? WEIGHT_W'(WEIGHT_ONE) : '0;
        end else if (a) begin
            w = WEIGHT_W'(WEIGHT_ONE) - frac;
        end else begin
            w = frac;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/echo_hiding_embedder.sv
// Echo hiding embedder. Each audio sample is written into a single-port delay line
// holding up to the last 1024 samples of the current frame, the zero-bit and
// one-bit taps are read back one after the other, and one shared 18x18 multiplier
// then forms the weighted blend and applies the gain over three passes before
// rounding and saturation. An accepted sample goes through the delay line write,
// two tap reads, the blend multiply, the blend add, two gain multiplies, the final
// add and the output register load in turn, as the delay line port and the shared
// multiplier allow. The next sample is accepted while a finished result waits in
// the output register, and a full output register only holds the final step.
// Message bits are taken on the first sample of each frame and o_frame_last marks
// the frame's end. Depends on ehe_pkg and echo_hiding_embedder_macros.svh.
`default_nettype none

`include "echo_hiding_embedder_macros.svh"

module echo_hiding_embedder import ehe_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0]  i_sample_in,
    input  wire logic                        i_frame_bit,
    input  wire logic                        i_following_bit,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [SAMPLE_W-1:0]       o_sample_out,
    output logic                             o_frame_last
);

    logic [DELAY_W-1:0]         r_delay_zero;
    logic [DELAY_W-1:0]         r_delay_one;
    logic [GAIN_W-1:0]          r_echo_gain;
    logic                       r_smoothing_on;

    t_state                     r_state;
    t_state                     n_state;
    logic [POS_W-1:0]           r_pos;
    logic [POS_W-1:0]           n_pos;
    logic [ADDR_W-1:0]          r_wptr;
    logic [ADDR_W-1:0]          n_wptr;
    logic [WEIGHT_W-1:0]        r_frac;
    logic [WEIGHT_W-1:0]        n_frac;
    logic [REM_W-1:0]           r_rem;
    logic [REM_W-1:0]           n_rem;
    logic                       r_earlier;
    logic                       r_cur;
    logic                       r_up;
    logic                       r_first;
    logic                       r_out_valid;

    logic signed [SAMPLE_W-1:0] mem [DELAY_MAX];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_x0;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_lo;
    logic signed [BLEND_W-1:0]  r_blend;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;

    logic                       in_accept;
    logic                       out_load;
    logic                       frame_last;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_addr;
    logic [ADDR_W-1:0]          lag0;
    logic [ADDR_W-1:0]          lag1;
    logic                       tap0_ok;
    logic                       tap1_ok;
    logic [ADDR_W-1:0]          rd_addr0;
    logic [ADDR_W-1:0]          rd_addr1;
    logic [WEIGHT_W-1:0]        weight;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic [REM_W-1:0]           rem_sum;
    logic signed [ECHO_W-1:0]   echo;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] sat;

    assign in_accept  = i_in_valid && o_in_ready;
    assign frame_last = (r_pos == POS_W'(FRAME_LEN - 1));
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_frame_last = r_out_last;

    assign lag0    = lag_of(r_delay_zero);
    assign lag1    = lag_of(r_delay_one);
    assign tap0_ok = 32'(r_pos) >= 32'(lag0);
    assign tap1_ok = 32'(r_pos) >= 32'(lag1);
    assign rd_addr0 = (r_wptr >= lag0) ? (r_wptr - lag0)
                    : ADDR_W'({1'b0, r_wptr} + (ADDR_W+1)'(DELAY_MAX) - {1'b0, lag0});
    assign rd_addr1 = (r_wptr >= lag1) ? (r_wptr - lag1)
                    : ADDR_W'({1'b0, r_wptr} + (ADDR_W+1)'(DELAY_MAX) - {1'b0, lag1});

    always_comb begin
        if (!r_smoothing_on) begin
            weight = r_cur ? WEIGHT_W'(WEIGHT_ONE) : '0;
        end else if (32'(r_pos) < 32'(RAMP_START)) begin
            if (32'(r_pos) < 32'(HEAD_END)) begin
                weight = ramp_weight(r_earlier, r_cur, r_frac);
            end else begin
                weight = r_cur ? WEIGHT_W'(WEIGHT_ONE) : '0;
            end
        end else begin
            weight = ramp_weight(r_cur, r_up, r_frac);
        end
    end

    assign x1   = tap1_ok ? r_rdata : '0;
    assign diff = (SAMPLE_W+1)'(x1) - (SAMPLE_W+1)'(r_x0);

    assign echo = r_acc[ACC_W-1:ROUND_POS];
    assign sum  = SUM_W'(r_x) + SUM_W'(echo);

    always_comb begin
        if (sum > SUM_W'(SAT_MAX)) begin
            sat = SAMPLE_W'(SAT_MAX);
        end else if (sum < SUM_W'(SAT_MIN)) begin
            sat = SAMPLE_W'(SAT_MIN);
        end else begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = r_wptr;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                mem_we     = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                mem_addr = rd_addr0;
                n_state  = S_RD1;
            end
            S_RD1: begin
                mem_addr = rd_addr1;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                mul_a   = MUL_W'({1'b0, weight});
                mul_b   = MUL_W'(diff);
                n_state = S_BLEND;
            end
            S_BLEND: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                mul_a   = MUL_W'({1'b0, r_echo_gain});
                mul_b   = MUL_W'({1'b0, r_blend[15:0]});
                n_state = S_MUL3;
            end
            S_MUL3: begin
                mul_a   = MUL_W'({1'b0, r_echo_gain});
                mul_b   = r_blend[BLEND_W-1:16];
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_sample_in;
        end
        r_rdata <= mem[mem_addr];
    end

    always_comb begin
        rem_sum = r_rem + REM_W'(REM_STEP);
        n_pos   = frame_last ? '0 : r_pos + POS_W'(1);
        if (frame_last || r_wptr == ADDR_W'(DELAY_MAX - 1)) begin
            n_wptr = '0;
        end else begin
            n_wptr = r_wptr + ADDR_W'(1);
        end
        if (n_pos == '0) begin
            n_frac = WEIGHT_W'(HEAD_FRAC0);
            n_rem  = REM_W'(HEAD_REM0);
        end else if (n_pos == POS_W'(RAMP_START)) begin
            n_frac = WEIGHT_W'(TAIL_FRAC0);
            n_rem  = REM_W'(TAIL_REM0);
        end else if (rem_sum >= REM_W'(RAMP_LEN)) begin
            n_frac = r_frac + WEIGHT_W'(FRAC_STEP + 1);
            n_rem  = rem_sum - REM_W'(RAMP_LEN);
        end else begin
            n_frac = r_frac + WEIGHT_W'(FRAC_STEP);
            n_rem  = rem_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_zero   <= DELAY_W'(RST_DELAY_ZERO);
            r_delay_one    <= DELAY_W'(RST_DELAY_ONE);
            r_echo_gain    <= GAIN_W'(RST_ECHO_GAIN);
            r_smoothing_on <= 1'(RST_SMOOTHING_ON);
            r_pos          <= '0;
            r_wptr         <= '0;
            r_frac         <= WEIGHT_W'(HEAD_FRAC0);
            r_rem          <= REM_W'(HEAD_REM0);
            r_earlier      <= 1'b0;
            r_cur          <= 1'b0;
            r_up           <= 1'b0;
            r_first        <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_DELAY_ZERO:   r_delay_zero   <= i_cfg_data[DELAY_W-1:0];
                    REG_DELAY_ONE:    r_delay_one    <= i_cfg_data[DELAY_W-1:0];
                    REG_ECHO_GAIN:    r_echo_gain    <= i_cfg_data[GAIN_W-1:0];
                    REG_SMOOTHING_ON: r_smoothing_on <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (in_accept && r_pos == '0) begin
                r_earlier <= r_first ? i_frame_bit : r_cur;
                r_cur     <= i_frame_bit;
                r_up      <= i_following_bit;
            end
            if (out_load) begin
                r_pos  <= n_pos;
                r_wptr <= n_wptr;
                r_frac <= n_frac;
                r_rem  <= n_rem;
                if (frame_last) begin
                    r_first <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_accept) begin
            r_x <= i_sample_in;
        end
        if (r_state == S_RD1) begin
            r_x0 <= tap0_ok ? r_rdata : '0;
        end
        if (r_state == S_BLEND) begin
            r_blend <= $signed({{2{r_x0[SAMPLE_W-1]}}, r_x0, 16'h0000})
                     + $signed(r_prod[BLEND_W-1:0]);
        end
        if (r_state == S_MUL3) begin
            r_lo <= r_prod;
        end
        if (r_state == S_SUM) begin
            r_acc <= (ACC_W'(r_prod) <<< 16) + ACC_W'(r_lo) + ACC_W'(ROUND_BIAS);
        end
        if (out_load) begin
            r_out_sample <= sat;
            r_out_last   <= frame_last;
        end
    end

    `EHE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !o_in_ready, "request accepted while busy")
    `EHE_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(FRAME_LEN - 1), "frame position out of range")
    `EHE_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, 1'b1, r_rem < REM_W'(RAMP_LEN), "ramp remainder out of range")
    `EHE_ASSERT_NXT(a_frame_wrap, i_clk, i_rst_n, out_load && frame_last, r_pos == '0 && r_wptr == '0, "frame did not wrap")
    `EHE_ASSERT_IMP(a_weight_range, i_clk, i_rst_n, r_state == S_MUL1, weight <= WEIGHT_W'(WEIGHT_ONE), "blend weight above one")

endmodule

`default_nettype wire
